// File: rtl/fsl_pkg.sv
// ----------------------------------------------------------------------------
// Free slot links package
// Constants, codes and controller/datapath interface types shared by the
// free slot list block.
// ----------------------------------------------------------------------------
package fsl_pkg;

    localparam int SLOTS  = 64;
    localparam int SLOT_W = 6;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int MODE_W = 2;
    localparam int ERR_W  = 2;

    localparam logic [MODE_W-1:0] MODE_PLACE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNDO  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PROBE = 2'd2;

    localparam logic [ERR_W-1:0] ERR_OK     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_PLACED = 2'd2;
    localparam logic [ERR_W-1:0] ERR_EMPTY  = 2'd3;

    typedef struct packed {
        logic load_in;   // capture the accepted request
        logic rd_input;  // read offsets of the slot on the input port
        logic pop_rd;    // read the top of the placement stack
        logic rd_stack;  // read offsets of the slot popped from the stack
        logic commit;    // write back links and load the result register
    } t_ctl_cmd;

    typedef struct packed {
        logic depth_zero;
    } t_ctl_sts;

endpackage

// File: rtl/fsl_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module fsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/fsl_ctl.sv
// ----------------------------------------------------------------------------
// Free slot links controller
// Sequences accept, stack pop (undo), offset read and write-back per request.
// ----------------------------------------------------------------------------
module fsl_ctl
    import fsl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [MODE_W-1:0] i_mode,
    output logic              o_valid,
    input  logic              i_ready,
    input  t_ctl_sts          i_sts,
    output t_ctl_cmd          o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_WRITE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_ready;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_in = 1'b1;
                    if (i_mode == MODE_UNDO && !i_sts.depth_zero) begin
                        o_cmd.pop_rd = 1'b1;
                        n_state      = S_POP;
                    end else begin
                        o_cmd.rd_input = 1'b1;
                        n_state        = S_WRITE;
                    end
                end
            end
            S_POP: begin
                o_cmd.rd_stack = 1'b1;
                n_state        = S_WRITE;
            end
            S_WRITE: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: rtl/fsl_dp.sv
// ----------------------------------------------------------------------------
// Free slot links datapath
// Offset memories with valid flags, placement stack, mask and result register.
// ----------------------------------------------------------------------------
module fsl_dp
    import fsl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctl_cmd          i_cmd,
    output t_ctl_sts          o_sts,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [SLOT_W-1:0] i_slot,
    output logic [SLOT_W-1:0] o_touched_slot,
    output logic [CNT_W-1:0]  o_free_count,
    output logic [CNT_W-1:0]  o_first_free,
    output logic [CNT_W-1:0]  o_next_free,
    output logic [ERR_W-1:0]  o_error
);

    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    // Request and control state.
    logic [MODE_W-1:0] r_mode;
    logic [SLOT_W-1:0] r_slot;
    logic [CNT_W-1:0]  r_depth;
    logic [SLOTS-1:0]  r_mask;
    logic [SLOTS:0]    r_fwd_vld;
    logic [SLOTS:0]    r_bwd_vld;
    logic              r_fq_vld;
    logic              r_bq_vld;
    logic [CNT_W-1:0]  r_head;

    // Result register.
    logic [SLOT_W-1:0] r_touched;
    logic [CNT_W-1:0]  r_free;
    logic [CNT_W-1:0]  r_first;
    logic [CNT_W-1:0]  r_next;
    logic [ERR_W-1:0]  r_err;

    // Memory ports.
    logic              rd_en;
    logic [SLOT_W-1:0] rd_slot;
    logic [CNT_W-1:0]  fwd_raddr;
    logic [CNT_W-1:0]  bwd_raddr;
    logic [CNT_W-1:0]  fwd_rdata;
    logic [CNT_W-1:0]  bwd_rdata;
    logic              fwd_we;
    logic              bwd_we;
    logic [CNT_W-1:0]  fwd_waddr;
    logic [CNT_W-1:0]  bwd_waddr;
    logic [CNT_W-1:0]  fwd_wdata;
    logic [CNT_W-1:0]  bwd_wdata;
    logic              stk_we;
    logic [SLOT_W-1:0] stk_waddr;
    logic [SLOT_W-1:0] stk_raddr;
    logic [SLOT_W-1:0] stk_rdata;

    // Item evaluation.
    logic              is_undo;
    logic              is_place;
    logic              out_of_range;
    logic [ERR_W-1:0]  err;
    logic              place_ok;
    logic              undo_ok;
    logic [CNT_W-1:0]  slot_x;
    logic [CNT_W-1:0]  nx;
    logic [CNT_W-1:0]  pv;
    logic [CNT_W-1:0]  depth_after;
    logic [CNT_W-1:0]  head_after;
    logic [CNT_W-1:0]  next_free;

    assign o_sts.depth_zero = (r_depth == '0);

    assign rd_en     = i_cmd.rd_input || i_cmd.rd_stack;
    assign rd_slot   = i_cmd.rd_input ? i_slot : stk_rdata;
    assign fwd_raddr = {1'b0, rd_slot} + ONE_C;
    assign bwd_raddr = {1'b0, rd_slot};
    assign stk_raddr = SLOT_W'(r_depth - ONE_C);

    // Entries never written read as an offset of one through their valid flags.
    assign nx = r_fq_vld ? fwd_rdata : ONE_C;
    assign pv = r_bq_vld ? bwd_rdata : ONE_C;

    assign is_undo      = (r_mode == MODE_UNDO);
    assign is_place     = (r_mode == MODE_PLACE);
    assign slot_x       = {1'b0, r_slot};
    assign out_of_range = !is_undo && (slot_x >= SLOTS_C);

    always_comb begin
        if (is_undo) begin
            err = (r_depth == '0) ? ERR_EMPTY : ERR_OK;
        end else if (out_of_range) begin
            err = ERR_RANGE;
        end else if (is_place && r_mask[r_slot]) begin
            err = ERR_PLACED;
        end else begin
            err = ERR_OK;
        end
    end

    assign place_ok = is_place && (err == ERR_OK);
    assign undo_ok  = is_undo && (err == ERR_OK);

    // The neighbours' offsets are known from the slot's own links, so the
    // write-back needs no read of the neighbours.
    assign fwd_we    = i_cmd.commit && (place_ok || undo_ok);
    assign bwd_we    = fwd_we;
    assign fwd_waddr = slot_x + ONE_C - pv;
    assign bwd_waddr = slot_x + nx;
    assign fwd_wdata = place_ok ? pv + nx : pv;
    assign bwd_wdata = place_ok ? pv + nx : nx;

    assign stk_we    = i_cmd.commit && place_ok;
    assign stk_waddr = r_depth[SLOT_W-1:0];

    always_comb begin
        if (place_ok) begin
            depth_after = r_depth + ONE_C;
        end else if (undo_ok) begin
            depth_after = r_depth - ONE_C;
        end else begin
            depth_after = r_depth;
        end
    end

    assign head_after = (fwd_we && fwd_waddr == '0) ? fwd_wdata : r_head;
    assign next_free  = (err == ERR_RANGE || err == ERR_EMPTY) ? SLOTS_C : slot_x + nx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth   <= '0;
            r_mask    <= '0;
            r_fwd_vld <= '0;
            r_bwd_vld <= '0;
            r_head    <= ONE_C;
        end else if (i_cmd.commit) begin
            r_depth <= depth_after;
            r_head  <= head_after;
            if (fwd_we) begin
                r_fwd_vld[fwd_waddr] <= 1'b1;
                r_bwd_vld[bwd_waddr] <= 1'b1;
                r_mask[r_slot]       <= place_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode <= i_mode;
            r_slot <= i_slot;
        end else if (i_cmd.rd_stack) begin
            r_slot <= stk_rdata;
        end
        if (rd_en) begin
            r_fq_vld <= r_fwd_vld[fwd_raddr];
            r_bq_vld <= r_bwd_vld[bwd_raddr];
        end
        if (i_cmd.commit) begin
            r_touched <= (place_ok || undo_ok) ? r_slot : '0;
            r_free    <= SLOTS_C - depth_after;
            r_first   <= head_after - ONE_C;
            r_next    <= next_free;
            r_err     <= err;
        end
    end

    fsl_ram #(
        .WIDTH (CNT_W),
        .DEPTH (SLOTS + 1)
    ) u_fwd_ram (
        .i_clk   (i_clk),
        .i_we    (fwd_we),
        .i_waddr (fwd_waddr),
        .i_wdata (fwd_wdata),
        .i_re    (rd_en),
        .i_raddr (fwd_raddr),
        .o_rdata (fwd_rdata)
    );

    fsl_ram #(
        .WIDTH (CNT_W),
        .DEPTH (SLOTS + 1)
    ) u_bwd_ram (
        .i_clk   (i_clk),
        .i_we    (bwd_we),
        .i_waddr (bwd_waddr),
        .i_wdata (bwd_wdata),
        .i_re    (rd_en),
        .i_raddr (bwd_raddr),
        .o_rdata (bwd_rdata)
    );

    fsl_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (r_slot),
        .i_re    (i_cmd.pop_rd),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign o_touched_slot = r_touched;
    assign o_free_count   = r_free;
    assign o_first_free   = r_first;
    assign o_next_free    = r_next;
    assign o_error        = r_err;

endmodule

// File: rtl/free_slot_links_with_undo.sv
// ----------------------------------------------------------------------------
// Free slot links with undo
// Free slot list held as relative forward and backward offsets, with a
// placement stack so that the latest placement can be taken back.
// ----------------------------------------------------------------------------
// Order: a request is taken only in the idle state; the offset memories are
// read and then the write-back loads the result register. An undo that pops
// the stack reads the stack before the offsets, an undo on an empty stack
// does not. The next request is taken only after the last one is written
// back, as set by the registered read of the offset memories followed by
// their write-back. A result not yet taken holds back the next write-back.
// Reset: synchronous and active low. The offset memories are not swept: a
// flag per entry makes an unwritten entry read as one, so requests are
// taken from the first cycle after reset.
// ----------------------------------------------------------------------------
module free_slot_links_with_undo
    import fsl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Request channel.
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [SLOT_W-1:0] i_slot,
    // Result channel.
    output logic              o_valid,
    input  logic              i_ready,
    output logic [SLOT_W-1:0] o_touched_slot,
    output logic [CNT_W-1:0]  o_free_count,
    output logic [CNT_W-1:0]  o_first_free,
    output logic [CNT_W-1:0]  o_next_free,
    output logic [ERR_W-1:0]  o_error
);

    // The controller walks each request through its memory accesses; the
    // datapath holds the lists, the stack and the result register. The
    // result register lets a new request be accepted while the previous
    // result is still waiting to be taken.
    t_ctl_cmd cmd;
    t_ctl_sts sts;

    fsl_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_mode  (i_mode),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Placing a slot unlinks it by writing its two neighbours' offsets; an
    // undo writes them back. The slot keeps its own offsets throughout, so
    // the relinking is exact and the neighbours' values follow from them.
    fsl_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_mode         (i_mode),
        .i_slot         (i_slot),
        .o_touched_slot (o_touched_slot),
        .o_free_count   (o_free_count),
        .o_first_free   (o_first_free),
        .o_next_free    (o_next_free),
        .o_error        (o_error)
    );

endmodule

// File: sim/free_slot_links_with_undo_checker.sv
// ----------------------------------------------------------------------------
// Free slot links checker
// Watches the request and result channels of the free slot list block. It
// keeps its own offset lists and placement stack, works out the result of
// every accepted request, and compares results in order, field by field.
// ----------------------------------------------------------------------------
module free_slot_links_with_undo_checker
    import fsl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic              i_res_valid,
    input  logic              i_res_ready,
    input  logic [SLOT_W-1:0] i_touched_slot,
    input  logic [CNT_W-1:0]  i_free_count,
    input  logic [CNT_W-1:0]  i_first_free,
    input  logic [CNT_W-1:0]  i_next_free,
    input  logic [ERR_W-1:0]  i_error,
    output int                o_mismatches,
    output int                o_outstanding,
    output int                o_checked
);

    typedef struct packed {
        logic [SLOT_W-1:0] touched;
        logic [CNT_W-1:0]  free_count;
        logic [CNT_W-1:0]  first_free;
        logic [CNT_W-1:0]  next_free;
        logic [ERR_W-1:0]  err;
    } t_slot_result;

    // Entry i of fwd_off is the forward offset of node i-1 (node -1 is the
    // head); entry i of bwd_off is the backward offset of node i (node SLOTS
    // is the tail).
    int unsigned       fwd_off [SLOTS+1];
    int unsigned       bwd_off [SLOTS+1];
    logic [SLOT_W-1:0] undo_stack [SLOTS];
    int unsigned       depth;
    logic [SLOTS-1:0]  taken;

    t_slot_result      results_due [$];
    t_slot_result      seen;
    t_slot_result      want;
    string             bad;
    int                fail_total = 0;
    int                result_total = 0;

    // Take slot s out of the list, or put it back. A removed slot keeps its
    // own offsets, so putting it back is exact.
    function automatic void splice(input int unsigned s, input bit relink);
        int unsigned nx;
        int unsigned pv;
        int unsigned a;
        int unsigned b;
        nx = fwd_off[s + 1];
        pv = bwd_off[s];
        a  = s + 1 - pv;
        b  = s + nx;
        if (a <= SLOTS) begin
            fwd_off[a] = relink ? fwd_off[a] - nx : fwd_off[a] + nx;
        end
        if (b <= SLOTS) begin
            bwd_off[b] = relink ? bwd_off[b] - pv : bwd_off[b] + pv;
        end
    endfunction

    function automatic t_slot_result predict_request(input logic [MODE_W-1:0] mode,
                                                     input logic [SLOT_W-1:0] slot);
        t_slot_result r;
        int unsigned  s;
        int unsigned  nxt;
        s         = slot;
        nxt       = SLOTS;
        r.touched = '0;
        r.err     = ERR_OK;
        if (mode == MODE_UNDO) begin
            if (depth == 0 || depth > SLOTS) begin
                r.err = ERR_EMPTY;
            end else begin
                depth--;
                s = undo_stack[depth];
                splice(s, 1'b1);
                taken[s]  = 1'b0;
                r.touched = SLOT_W'(s);
                nxt       = s + fwd_off[s + 1];
            end
        end else if (s >= SLOTS) begin
            r.err = ERR_RANGE;
        end else if (mode == MODE_PLACE) begin
            if (taken[s]) begin
                r.err = ERR_PLACED;
            end else if (depth < SLOTS) begin
                splice(s, 1'b0);
                taken[s]          = 1'b1;
                undo_stack[depth] = SLOT_W'(s);
                depth++;
                r.touched = SLOT_W'(s);
            end
            nxt = s + fwd_off[s + 1];
        end else begin
            // Probe, and the spare mode code behaves the same way.
            nxt = s + fwd_off[s + 1];
        end
        r.free_count = CNT_W'(SLOTS - depth);
        r.first_free = CNT_W'(fwd_off[0] - 1);
        r.next_free  = CNT_W'(nxt);
        return r;
    endfunction

    function automatic string show(input t_slot_result r);
        return $sformatf("touched=%0d free=%0d first=%0d next=%0d err=%0d",
                         r.touched, r.free_count, r.first_free, r.next_free, r.err);
    endfunction

    task automatic note_failure(input string msg);
        fail_total++;
        if (fail_total <= 10) begin
            $display("MISMATCH: %s", msg);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= SLOTS; k++) begin
                fwd_off[k] = 1;
                bwd_off[k] = 1;
            end
            for (int k = 0; k < SLOTS; k++) begin
                undo_stack[k] = '0;
            end
            depth = 0;
            taken = '0;
            results_due.delete();
        end else begin
            // Results first: the block never answers in the cycle it accepts.
            if (i_res_valid && i_res_ready) begin
                seen = '{i_touched_slot, i_free_count, i_first_free, i_next_free, i_error};
                result_total++;
                if (results_due.size() == 0) begin
                    note_failure($sformatf("result %0d arrived with none due: %s",
                                           result_total, show(seen)));
                end else begin
                    want = results_due.pop_front();
                    bad  = "";
                    if (seen.touched !== want.touched) bad = {bad, " touched_slot"};
                    if (seen.free_count !== want.free_count) bad = {bad, " free_count"};
                    if (seen.first_free !== want.first_free) bad = {bad, " first_free"};
                    if (seen.next_free !== want.next_free) bad = {bad, " next_free"};
                    if (seen.err !== want.err) bad = {bad, " error"};
                    if (bad.len() != 0) begin
                        note_failure($sformatf("result %0d,%s wrong: expected %s, got %s",
                                               result_total, bad, show(want), show(seen)));
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                results_due.push_back(predict_request(i_mode, i_slot));
            end
        end
        o_mismatches  <= fail_total;
        o_checked     <= result_total;
        o_outstanding <= results_due.size();
    end

endmodule

// File: sim/free_slot_links_with_undo_tb.sv
// ----------------------------------------------------------------------------
// Free slot links testbench
// Drives place, undo and probe requests into the free slot list block with
// random gaps on both channels. A short directed opening covers the edge
// slots and the placed and empty errors; random episodes then mix placements,
// undos and probes, and now and then fill the whole list and unwind it
// again. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module free_slot_links_with_undo_tb;
    import fsl_pkg::*;

    // The mode field is two bits wide; the fourth code has no operation of
    // its own and must behave like a probe.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam int ITEMS_TARGET = 1150;
    localparam int LIMIT_CYCLES = 300000;
    // Idle margin after the last result has come back, before the verdict.
    localparam int TAIL_CYCLES  = 16;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [MODE_W-1:0] i_mode;
    logic [SLOT_W-1:0] i_slot;
    logic              o_valid;
    logic              i_ready;
    logic [SLOT_W-1:0] o_touched_slot;
    logic [CNT_W-1:0]  o_free_count;
    logic [CNT_W-1:0]  o_first_free;
    logic [CNT_W-1:0]  o_next_free;
    logic [ERR_W-1:0]  o_error;

    int mismatches;
    int outstanding;
    int checked;

    // Stimulus bookkeeping: a shadow of which slots are placed and in what
    // order, used only to steer requests towards interesting states.
    logic [SLOTS-1:0] shadow_taken = '0;
    int               shadow_stack [$];
    int               sent = 0;
    int               place_sent = 0;
    int               undo_sent = 0;
    int               probe_sent = 0;
    int               spare_sent = 0;
    int               fills = 0;
    int               pauses = 0;
    int               tx_calm = 0;
    int               rx_calm = 0;
    int               cycle_count = 0;

    free_slot_links_with_undo dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_slot         (i_slot),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_touched_slot (o_touched_slot),
        .o_free_count   (o_free_count),
        .o_first_free   (o_first_free),
        .o_next_free    (o_next_free),
        .o_error        (o_error)
    );

    free_slot_links_with_undo_checker link_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_ready    (o_ready),
        .i_mode         (i_mode),
        .i_slot         (i_slot),
        .i_res_valid    (o_valid),
        .i_res_ready    (i_ready),
        .i_touched_slot (o_touched_slot),
        .i_free_count   (o_free_count),
        .i_first_free   (o_first_free),
        .i_next_free    (o_next_free),
        .i_error        (o_error),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding),
        .o_checked      (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake must not leave the run spinning for ever.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, outstanding);
            $display("Verification failed");
            $finish;
        end
    end

    // Idle cycles before the next request or result. Most draws are 0 to 7,
    // but every so often a calm stretch with no idling at all begins, so that
    // back-to-back traffic is exercised as well.
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 40);
        end
        return $urandom_range(0, 7);
    endfunction

    // Random free or placed slot, or -1 when there is none of that kind.
    function automatic int pick_slot(input bit want_taken);
        int start;
        int idx;
        start = $urandom_range(0, SLOTS - 1);
        for (int k = 0; k < SLOTS; k++) begin
            idx = (start + k) % SLOTS;
            if (shadow_taken[idx] == want_taken) begin
                return idx;
            end
        end
        return -1;
    endfunction

    // Present one request and hold it until the block takes it. On return we
    // sit in the time step of the accepting edge, with valid still high; the
    // next request either replaces the payload in this step or lowers valid
    // for its gap, so valid receives a single assignment per step.
    task automatic send_request(input logic [MODE_W-1:0] mode, input int slot);
        int gap;
        gap = draw_gap(tx_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode  <= mode;
        i_slot  <= SLOT_W'(slot);
        do @(posedge i_clk); while (!o_ready);
        sent++;
        case (mode)
            MODE_PLACE: begin
                place_sent++;
                if (!shadow_taken[slot]) begin
                    shadow_taken[slot] = 1'b1;
                    shadow_stack.push_back(slot);
                end
            end
            MODE_UNDO: begin
                undo_sent++;
                if (shadow_stack.size() > 0) begin
                    shadow_taken[shadow_stack.pop_back()] = 1'b0;
                end
            end
            MODE_PROBE: probe_sent++;
            default: spare_sent++;
        endcase
    endtask

    // Stop sending until every result due has come back. Valid is lowered
    // first, and at least one edge passes, so the last request is not taken
    // twice and valid is never lowered and raised in the same step.
    task automatic drain_pause();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic run_directed();
        send_request(MODE_PROBE, 0);
        send_request(MODE_PROBE, SLOTS - 1);
        send_request(MODE_UNDO, 0);              // nothing placed yet
        send_request(MODE_PLACE, 0);
        send_request(MODE_PLACE, SLOTS - 1);
        send_request(MODE_PLACE, 0);             // already placed
        send_request(MODE_PLACE, 31);
        send_request(MODE_PROBE, 31);            // placed slot keeps its old link
        send_request(MODE_PROBE, 30);
        send_request(MODE_SPARE, 42);
        send_request(MODE_PLACE, 32);
        send_request(MODE_PLACE, 30);
        send_request(MODE_PROBE, 29);
        repeat (5) send_request(MODE_UNDO, SLOTS - 1);
        send_request(MODE_UNDO, 21);             // stack empty again
        send_request(MODE_PLACE, SLOTS - 2);
        send_request(MODE_PROBE, SLOTS - 1);
        send_request(MODE_UNDO, 0);
    endtask

    // A stretch of ordinary traffic. Placements of free slots outweigh undos,
    // so the stack depth wanders over its whole range.
    task automatic mixed_run(input int count);
        int roll;
        int pick;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                pick = pick_slot(1'b0);
                if (pick >= 0) begin
                    send_request(MODE_PLACE, pick);
                end else begin
                    send_request(MODE_UNDO, $urandom_range(0, SLOTS - 1));
                end
            end else if (roll < 70) begin
                send_request(MODE_UNDO, $urandom_range(0, SLOTS - 1));
            end else if (roll < 85) begin
                send_request(MODE_PROBE, $urandom_range(0, SLOTS - 1));
            end else if (roll < 93) begin
                pick = pick_slot(1'b1);
                send_request(MODE_PLACE, pick >= 0 ? pick : $urandom_range(0, SLOTS - 1));
            end else if (roll < 97) begin
                send_request(MODE_SPARE, $urandom_range(0, SLOTS - 1));
            end else begin
                send_request(MODE_PLACE, $urandom_range(0, SLOTS - 1));
            end
        end
    endtask

    // Place every free slot in random order until the list is empty, try one
    // more placement, then unwind the whole stack and undo once too often.
    task automatic fill_and_drain();
        int pick;
        fills++;
        pick = pick_slot(1'b0);
        while (pick >= 0) begin
            send_request(MODE_PLACE, pick);
            if ($urandom_range(0, 7) == 0) begin
                send_request(MODE_PROBE, $urandom_range(0, SLOTS - 1));
            end
            pick = pick_slot(1'b0);
        end
        send_request(MODE_PLACE, $urandom_range(0, SLOTS - 1));
        send_request(MODE_PROBE, $urandom_range(0, SLOTS - 1));
        while (shadow_stack.size() > 0) begin
            send_request(MODE_UNDO, $urandom_range(0, SLOTS - 1));
            if ($urandom_range(0, 7) == 0) begin
                send_request(MODE_PROBE, $urandom_range(0, SLOTS - 1));
            end
        end
        send_request(MODE_UNDO, $urandom_range(0, SLOTS - 1));
    endtask

    // Result side: stall for a drawn number of cycles before each result.
    initial begin
        int stall;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = draw_gap(rx_calm);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Request side and verdict.
    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_mode  <= MODE_PLACE;
        i_slot  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        drain_pause();
        pauses++;

        while (sent < ITEMS_TARGET) begin
            if ($urandom_range(0, 9) == 0 || (fills == 0 && sent > 200)) begin
                fill_and_drain();
            end else begin
                mixed_run($urandom_range(20, 60));
            end
            if ($urandom_range(0, 7) == 0) begin
                drain_pause();
                pauses++;
            end
        end

        drain_pause();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests: %0d place, %0d undo, %0d probe, %0d spare mode.",
                 sent, place_sent, undo_sent, probe_sent, spare_sent);
        $display("Checked %0d results over %0d full fill-and-unwind passes and %0d drains.",
                 checked, fills, pauses);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d results failed their check", mismatches);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
